/* hdl/rotenc_pkg.sv */
`default_nettype none

package rotenc_pkg;

    // Field widths of the item and result channels.
    localparam int unsigned NOW_W   = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned STEPS_W = 4;

    // Register file layout.
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd4;

    // Register widths and reset values.
    localparam int unsigned ACCEL_THR_W   = 10;
    localparam int unsigned ACCEL_FACT_W  = 4;
    localparam int unsigned LONG_PRESS_W  = 14;
    localparam int unsigned DEBOUNCE_W    = 10;
    localparam int unsigned POLL_INT_W    = 16;

    localparam logic [ACCEL_THR_W-1:0]  RST_ACCEL_THR  = 10'd40;
    localparam logic [ACCEL_FACT_W-1:0] RST_ACCEL_FACT = 4'd4;
    localparam logic [LONG_PRESS_W-1:0] RST_LONG_PRESS = 14'd800;
    localparam logic [DEBOUNCE_W-1:0]   RST_DEBOUNCE   = 10'd50;
    localparam logic [POLL_INT_W-1:0]   RST_POLL_INT   = 16'd1000;

    // Millisecond thresholds are kept scaled to microseconds.
    localparam int unsigned US_PER_MS = 1000;
    localparam int unsigned THR_US_W  = 20;
    localparam int unsigned LONG_US_W = 24;
    localparam int unsigned DEB_US_W  = 20;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_PRESS = 3'd3,
        EV_LONG  = 3'd4,
        EV_LOG   = 3'd5
    } t_event_kind;

    // Half-step from the previous and new A/B pair, index {prev, new}.
    function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/rotenc_in_if.sv */
`default_nettype none

interface rotenc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic                            enc_a;
    logic                            enc_b;
    logic                            sw_level;
    logic                            log_level;
    logic [rotenc_pkg::NOW_W-1:0]    now_us;

    modport source (
        output valid, op, enc_a, enc_b, sw_level, log_level, now_us,
        input  ready
    );
    modport sink (
        input  valid, op, enc_a, enc_b, sw_level, log_level, now_us,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/rotenc_out_if.sv */
`default_nettype none

interface rotenc_out_if;
    logic                              valid;
    logic                              ready;
    logic [rotenc_pkg::KIND_W-1:0]     event_kind;
    logic [rotenc_pkg::STEPS_W-1:0]    step_count;
    logic                              button_held;

    modport source (
        output valid, event_kind, step_count, button_held,
        input  ready
    );
    modport sink (
        input  valid, event_kind, step_count, button_held,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/rotary_encoder_event_unit.sv */
`default_nettype none

// Rotary encoder event unit. Each transfer on i_in is either an encoder pin change (op 0)
// or a button poll (op 1), and each produces exactly one result transfer on o_out. A pin
// change decodes the A/B levels into half-steps; two half-steps in one direction queue a
// clockwise or counterclockwise event whose step count is the acceleration factor (or 1
// for a zero factor) when the gap to the previous detent is at least 1 ms and below the
// threshold. A poll samples both active-low buttons once the poll interval has passed,
// queues press, long press or logger press events on release, and then removes the
// oldest queued event and reports it (kind 0 with step count 0 when the queue is empty).
// The queue holds QUEUE_DEPTH-1 events; an event that finds it full is dropped. The unit
// takes one item per clock and delivers its result in the following cycle through an
// output register, so it sustains one item per cycle while o_out keeps up. Events live in
// a synchronous ring memory whose registered read port prefetches the slot at the queue
// tail; a slot written in the same cycle is forwarded. A poll may queue an encoder button
// event and a logger event together, so a slot carries one event plus a flag for a
// trailing logger press. Registers are written over APB at byte address 4*index and read
// back at field width; millisecond limits are scaled to microseconds when written.

module rotary_encoder_event_unit #(
    parameter int unsigned QUEUE_DEPTH = rotenc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    rotenc_in_if.sink                            i_in,
    rotenc_out_if.source                         o_out,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [rotenc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire  [rotenc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rotenc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W-1:0] CNT_ROOM2  = PTR_W'(QUEUE_DEPTH - 2);
    localparam logic [31:0]      ONE_MS_US  = 32'(rotenc_pkg::US_PER_MS);

    typedef struct packed {
        rotenc_pkg::t_event_kind             kind;
        logic [rotenc_pkg::STEPS_W-1:0]      steps;
        logic                                log_extra;
    } t_slot;

    // Configuration registers and their microsecond-scaled copies.
    logic [rotenc_pkg::ACCEL_THR_W-1:0]   r_accel_thr;
    logic [rotenc_pkg::ACCEL_FACT_W-1:0]  r_accel_fact;
    logic [rotenc_pkg::LONG_PRESS_W-1:0]  r_long_press;
    logic [rotenc_pkg::DEBOUNCE_W-1:0]    r_debounce;
    logic [rotenc_pkg::POLL_INT_W-1:0]    r_poll_int;
    logic [rotenc_pkg::THR_US_W-1:0]      r_thr_us;
    logic [rotenc_pkg::LONG_US_W-1:0]     r_long_us;
    logic [rotenc_pkg::DEB_US_W-1:0]      r_deb_us;

    // Decoder and button state.
    logic [1:0]         r_quad,      n_quad;
    logic signed [1:0]  r_half,      n_half;
    logic [31:0]        r_det_time,  n_det_time;
    logic [31:0]        r_poll_time, n_poll_time;
    logic               r_sw_prev,   n_sw_prev;
    logic               r_sw_down,   n_sw_down;
    logic [31:0]        r_sw_time,   n_sw_time;
    logic               r_lg_prev,   n_lg_prev;
    logic               r_lg_down,   n_lg_down;
    logic [31:0]        r_lg_time,   n_lg_time;

    // Event ring.
    t_slot              r_mem [QUEUE_DEPTH];
    t_slot              r_rd;
    logic [PTR_W-1:0]   r_head,  n_head;
    logic [PTR_W-1:0]   r_tail,  n_tail;
    logic [PTR_W-1:0]   r_count, n_count;
    logic               r_sub,   n_sub;

    // Output register.
    logic                               r_out_valid;
    logic [rotenc_pkg::KIND_W-1:0]      r_out_kind,  n_out_kind;
    logic [rotenc_pkg::STEPS_W-1:0]     r_out_steps, n_out_steps;

    logic        acc;
    logic        cfg_we;
    logic [rotenc_pkg::CFG_IDX_W-1:0] cfg_idx;

    // Combinational work signals.
    logic [1:0]                    pin_pair;
    logic signed [1:0]             half_d;
    logic signed [2:0]             half_sum;
    logic [31:0]                   det_gap;
    logic [31:0]                   poll_gap;
    logic [31:0]                   sw_held;
    logic [31:0]                   lg_held;
    logic                          want0;
    logic                          want1;
    logic                          push0;
    logic                          push1;
    t_slot                         w_slot;
    t_slot                         pop_slot;
    logic [PTR_W:0]                total;
    logic                          pop;

    assign acc        = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.event_kind  = r_out_kind;
    assign o_out.step_count  = r_out_steps;
    assign o_out.button_held = r_sw_down;

    // APB register file: always ready, written on the access phase.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[rotenc_pkg::CFG_ADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            rotenc_pkg::REG_ACCEL_THRESHOLD: prdata = 32'(r_accel_thr);
            rotenc_pkg::REG_ACCEL_FACTOR:    prdata = 32'(r_accel_fact);
            rotenc_pkg::REG_LONG_PRESS:      prdata = 32'(r_long_press);
            rotenc_pkg::REG_DEBOUNCE:        prdata = 32'(r_debounce);
            rotenc_pkg::REG_POLL_INTERVAL:   prdata = 32'(r_poll_int);
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_thr  <= rotenc_pkg::RST_ACCEL_THR;
            r_accel_fact <= rotenc_pkg::RST_ACCEL_FACT;
            r_long_press <= rotenc_pkg::RST_LONG_PRESS;
            r_debounce   <= rotenc_pkg::RST_DEBOUNCE;
            r_poll_int   <= rotenc_pkg::RST_POLL_INT;
            r_thr_us     <= rotenc_pkg::THR_US_W'(32'(rotenc_pkg::RST_ACCEL_THR)
                                                 * rotenc_pkg::US_PER_MS);
            r_long_us    <= rotenc_pkg::LONG_US_W'(32'(rotenc_pkg::RST_LONG_PRESS)
                                                  * rotenc_pkg::US_PER_MS);
            r_deb_us     <= rotenc_pkg::DEB_US_W'(32'(rotenc_pkg::RST_DEBOUNCE)
                                                 * rotenc_pkg::US_PER_MS);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                rotenc_pkg::REG_ACCEL_THRESHOLD: begin
                    r_accel_thr <= pwdata[rotenc_pkg::ACCEL_THR_W-1:0];
                    r_thr_us    <= rotenc_pkg::THR_US_W'(
                        32'(pwdata[rotenc_pkg::ACCEL_THR_W-1:0]) * rotenc_pkg::US_PER_MS);
                end
                rotenc_pkg::REG_ACCEL_FACTOR: begin
                    r_accel_fact <= pwdata[rotenc_pkg::ACCEL_FACT_W-1:0];
                end
                rotenc_pkg::REG_LONG_PRESS: begin
                    r_long_press <= pwdata[rotenc_pkg::LONG_PRESS_W-1:0];
                    r_long_us    <= rotenc_pkg::LONG_US_W'(
                        32'(pwdata[rotenc_pkg::LONG_PRESS_W-1:0]) * rotenc_pkg::US_PER_MS);
                end
                rotenc_pkg::REG_DEBOUNCE: begin
                    r_debounce <= pwdata[rotenc_pkg::DEBOUNCE_W-1:0];
                    r_deb_us   <= rotenc_pkg::DEB_US_W'(
                        32'(pwdata[rotenc_pkg::DEBOUNCE_W-1:0]) * rotenc_pkg::US_PER_MS);
                end
                rotenc_pkg::REG_POLL_INTERVAL: begin
                    r_poll_int <= pwdata[rotenc_pkg::POLL_INT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Item processing. All differences of time stamps wrap modulo 2^32, and a
    // comparison against a millisecond limit is done on the scaled microsecond value,
    // which gives the same answer as comparing whole milliseconds.
    always_comb begin
        n_quad      = r_quad;
        n_half      = r_half;
        n_det_time  = r_det_time;
        n_poll_time = r_poll_time;
        n_sw_prev   = r_sw_prev;
        n_sw_down   = r_sw_down;
        n_sw_time   = r_sw_time;
        n_lg_prev   = r_lg_prev;
        n_lg_down   = r_lg_down;
        n_lg_time   = r_lg_time;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sub       = r_sub;
        n_out_kind  = rotenc_pkg::EV_NONE;
        n_out_steps = '0;

        want0        = 1'b0;
        want1        = 1'b0;
        w_slot       = '{kind: rotenc_pkg::EV_NONE, steps: '0, log_extra: 1'b0};

        pin_pair = {i_in.enc_a, i_in.enc_b};
        half_d   = rotenc_pkg::gray_delta({r_quad, pin_pair});
        half_sum = 3'(r_half) + 3'(half_d);
        det_gap  = i_in.now_us - r_det_time;
        poll_gap = i_in.now_us - r_poll_time;
        sw_held  = i_in.now_us - r_sw_time;
        lg_held  = i_in.now_us - r_lg_time;

        if (i_in.op == 1'b0) begin
            n_quad = pin_pair;
            if (half_d != 2'sd0) begin
                if (half_sum >= 3'sd2 || half_sum <= -3'sd2) begin
                    n_half       = 2'sd0;
                    n_det_time   = i_in.now_us;
                    want0        = 1'b1;
                    w_slot.kind  = (half_sum > 3'sd0) ? rotenc_pkg::EV_CW
                                                      : rotenc_pkg::EV_CCW;
                    w_slot.steps = 4'd1;
                    if (det_gap >= ONE_MS_US && det_gap < 32'(r_thr_us)) begin
                        w_slot.steps = (r_accel_fact == '0) ? 4'd1 : r_accel_fact;
                    end
                end else begin
                    n_half = half_sum[1:0];
                end
            end
        end else if (poll_gap >= 32'(r_poll_int)) begin
            n_poll_time = i_in.now_us;
            if (i_in.sw_level != r_sw_prev) begin
                n_sw_prev = i_in.sw_level;
                if (i_in.sw_level == 1'b0) begin
                    n_sw_down = 1'b1;
                    n_sw_time = i_in.now_us;
                end else if (r_sw_down) begin
                    n_sw_down = 1'b0;
                    if (sw_held >= 32'(r_long_us)) begin
                        want0       = 1'b1;
                        w_slot.kind = rotenc_pkg::EV_LONG;
                    end else if (sw_held >= 32'(r_deb_us)) begin
                        want0       = 1'b1;
                        w_slot.kind = rotenc_pkg::EV_PRESS;
                    end
                end
            end
            if (i_in.log_level != r_lg_prev) begin
                n_lg_prev = i_in.log_level;
                if (i_in.log_level == 1'b0) begin
                    n_lg_down = 1'b1;
                    n_lg_time = i_in.now_us;
                end else if (r_lg_down) begin
                    n_lg_down = 1'b0;
                    if (lg_held >= 32'(r_deb_us)) begin
                        // A logger press behind an encoder button event rides in the
                        // same slot as its trailing flag.
                        if (want0) begin
                            want1 = 1'b1;
                        end else begin
                            want0       = 1'b1;
                            w_slot.kind = rotenc_pkg::EV_LOG;
                        end
                    end
                end
            end
            if (want0) begin
                w_slot.steps = 4'd1;
            end
        end

        // Room checks: the ring takes at most QUEUE_DEPTH-1 events.
        push0 = want0 && (r_count != PTR_LAST);
        push1 = want1 && (QUEUE_DEPTH > 2) && (r_count < CNT_ROOM2);
        w_slot.log_extra = push1;

        if (push0) begin
            n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
        end

        // The poll dequeues after its own pushes; an empty ring pops the slot that is
        // being written right now.
        total    = {1'b0, r_count} + (PTR_W+1)'(push0) + (PTR_W+1)'(push1);
        pop      = (i_in.op == 1'b1) && (total != '0);
        pop_slot = (r_count == '0) ? w_slot : r_rd;

        if (pop) begin
            if (r_sub && r_count != '0) begin
                n_out_kind  = rotenc_pkg::EV_LOG;
                n_out_steps = 4'd1;
                n_sub       = 1'b0;
                n_tail      = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            end else begin
                n_out_kind  = pop_slot.kind;
                n_out_steps = pop_slot.steps;
                if (pop_slot.log_extra) begin
                    n_sub = 1'b1;
                end else begin
                    n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                end
            end
        end

        n_count = PTR_W'(total - (PTR_W+1)'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad      <= 2'b11;
            r_half      <= 2'sd0;
            r_det_time  <= '0;
            r_poll_time <= '0;
            r_sw_prev   <= 1'b1;
            r_sw_down   <= 1'b0;
            r_sw_time   <= '0;
            r_lg_prev   <= 1'b1;
            r_lg_down   <= 1'b0;
            r_lg_time   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_quad      <= n_quad;
                r_half      <= n_half;
                r_det_time  <= n_det_time;
                r_poll_time <= n_poll_time;
                r_sw_prev   <= n_sw_prev;
                r_sw_down   <= n_sw_down;
                r_sw_time   <= n_sw_time;
                r_lg_prev   <= n_lg_prev;
                r_lg_down   <= n_lg_down;
                r_lg_time   <= n_lg_time;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_sub       <= n_sub;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_kind  <= n_out_kind;
            r_out_steps <= n_out_steps;
        end
    end

    // Ring memory: one write port at the head, one registered read port that
    // prefetches the slot at the next tail, bypassing a write to that same slot.
    always_ff @(posedge i_clk) begin
        if (acc && push0) begin
            r_mem[r_head] <= w_slot;
        end
        if (acc && push0 && (n_tail == r_head)) begin
            r_rd <= w_slot;
        end else if (acc) begin
            r_rd <= r_mem[n_tail];
        end else begin
            r_rd <= r_mem[r_tail];
        end
    end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the rotary encoder event unit. Items go in over the input channel, one
// report per item comes back over the output channel, and every report is compared with
// the report that a predictor inside this module works out for the same item.
module tb_top;

    localparam int HALF_PERIOD  = 1;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 4;
    localparam int EVQ_DEPTH    = rotenc_pkg::DEF_QUEUE_DEPTH;
    localparam int MAX_REPORTED = 10;

    // Item operation codes.
    localparam bit OP_PIN  = 1'b0;
    localparam bit OP_POLL = 1'b1;

    // Half-step for the index {previous A/B pair, new A/B pair}.
    localparam int QUAD_DELTA [16] = '{ 0, -1,  1,  0,
                                        1,  0,  0, -1,
                                       -1,  0,  0,  1,
                                        0,  1, -1,  0};

    // Next A/B pair for one clockwise or counterclockwise half-step.
    localparam bit [1:0] CW_NEXT  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
    localparam bit [1:0] CCW_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

    typedef struct {
        bit                         op;
        bit                         a;
        bit                         b;
        bit                         sw;
        bit                         lg;
        bit [rotenc_pkg::NOW_W-1:0] now;
    } t_enc_item;

    typedef struct {
        rotenc_pkg::t_event_kind      kind;
        bit [rotenc_pkg::STEPS_W-1:0] steps;
        bit                           held;
    } t_report;

    typedef struct {
        bit [rotenc_pkg::ACCEL_THR_W-1:0]  thr;
        bit [rotenc_pkg::ACCEL_FACT_W-1:0] fac;
        bit [rotenc_pkg::LONG_PRESS_W-1:0] lng;
        bit [rotenc_pkg::DEBOUNCE_W-1:0]   deb;
        bit [rotenc_pkg::POLL_INT_W-1:0]   poll;
    } t_setting;

    // ------------------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [rotenc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [rotenc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [rotenc_pkg::CFG_DATA_W-1:0] prdata;
    logic                              pready;

    rotenc_in_if  enc_in ();
    rotenc_out_if ev_out ();

    always #(HALF_PERIOD) i_clk = ~i_clk;

    rotary_encoder_event_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (enc_in),
        .o_out   (ev_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------------------
    // Predictor state. The initial values are the state right after reset, and reset is
    // applied only once, so no separate clear is needed.
    // ------------------------------------------------------------------------------------
    bit [rotenc_pkg::ACCEL_THR_W-1:0]  thr_ms  = rotenc_pkg::RST_ACCEL_THR;
    bit [rotenc_pkg::ACCEL_FACT_W-1:0] fac     = rotenc_pkg::RST_ACCEL_FACT;
    bit [rotenc_pkg::LONG_PRESS_W-1:0] long_ms = rotenc_pkg::RST_LONG_PRESS;
    bit [rotenc_pkg::DEBOUNCE_W-1:0]   deb_ms  = rotenc_pkg::RST_DEBOUNCE;
    bit [rotenc_pkg::POLL_INT_W-1:0]   poll_us = rotenc_pkg::RST_POLL_INT;

    bit [1:0]                   quad_prev     = 2'd3;
    int                         half_steps    = 0;
    bit [rotenc_pkg::NOW_W-1:0] detent_time   = '0;
    bit [rotenc_pkg::NOW_W-1:0] poll_time     = '0;
    bit                         sw_down       = 1'b0;
    bit [rotenc_pkg::NOW_W-1:0] sw_down_time  = '0;
    bit                         sw_last_level = 1'b1;
    bit                         lg_down       = 1'b0;
    bit [rotenc_pkg::NOW_W-1:0] lg_down_time  = '0;
    bit                         lg_last_level = 1'b1;

    // Pending event ring; one slot is always left free, so it holds EVQ_DEPTH-1 events.
    rotenc_pkg::t_event_kind      ring_kind  [EVQ_DEPTH];
    bit [rotenc_pkg::STEPS_W-1:0] ring_steps [EVQ_DEPTH];
    int                           ring_wr = 0;
    int                           ring_rd = 0;

    t_report expected_reports [$];
    int      fail_count   = 0;
    int      report_count = 0;
    int      stall_cycles = 0;

    // Stimulus state: the levels last sent on each line and the running microsecond clock.
    bit [1:0]                   stim_ab = 2'd3;
    bit                         stim_sw = 1'b1;
    bit                         stim_lg = 1'b1;
    bit [rotenc_pkg::NOW_W-1:0] tb_now  = '0;

    // Idle controls for the sender and the receiver.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_len     = 0;

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // A new event is dropped when the ring is already full.
    function automatic void push_event(input rotenc_pkg::t_event_kind k,
                                       input bit [rotenc_pkg::STEPS_W-1:0] n);
        int nxt;
        nxt = (ring_wr + 1) % EVQ_DEPTH;
        if (nxt != ring_rd) begin
            ring_kind[ring_wr]  = k;
            ring_steps[ring_wr] = n;
            ring_wr = nxt;
        end
    endfunction

    // Invalid transitions (no change or both lines at once) still move the stored pair.
    function automatic void step_encoder(input bit a, input bit b,
                                         input bit [rotenc_pkg::NOW_W-1:0] now);
        bit [1:0]                     ab;
        int                           d;
        bit [rotenc_pkg::NOW_W-1:0]   gap;
        bit [rotenc_pkg::STEPS_W-1:0] n;
        rotenc_pkg::t_event_kind      k;
        ab = {a, b};
        d = QUAD_DELTA[{quad_prev, ab}];
        quad_prev = ab;
        if (d != 0) begin
            half_steps += d;
            if (half_steps >= 2 || half_steps <= -2) begin
                k = (half_steps > 0) ? rotenc_pkg::EV_CW : rotenc_pkg::EV_CCW;
                gap = (now - detent_time) / rotenc_pkg::US_PER_MS;
                n = 4'd1;
                half_steps = 0;
                detent_time = now;
                // A zero factor still counts one step for a fast detent.
                if (gap > 0 && gap < thr_ms) begin
                    n = (fac != 0) ? fac : 4'd1;
                end
                push_event(k, n);
            end
        end
    endfunction

    function automatic void sample_buttons(input bit sw, input bit lg,
                                           input bit [rotenc_pkg::NOW_W-1:0] now);
        bit [rotenc_pkg::NOW_W-1:0] held;
        // With a zero interval every poll samples the buttons.
        if (now - poll_time < poll_us) begin
            return;
        end
        poll_time = now;
        if (sw != sw_last_level) begin
            sw_last_level = sw;
            if (!sw) begin
                sw_down = 1'b1;
                sw_down_time = now;
            end else if (sw_down) begin
                held = (now - sw_down_time) / rotenc_pkg::US_PER_MS;
                sw_down = 1'b0;
                if (held >= long_ms) begin
                    push_event(rotenc_pkg::EV_LONG, 4'd1);
                end else if (held >= deb_ms) begin
                    push_event(rotenc_pkg::EV_PRESS, 4'd1);
                end
            end
        end
        if (lg != lg_last_level) begin
            lg_last_level = lg;
            if (!lg) begin
                lg_down = 1'b1;
                lg_down_time = now;
            end else if (lg_down) begin
                held = (now - lg_down_time) / rotenc_pkg::US_PER_MS;
                lg_down = 1'b0;
                if (held >= deb_ms) begin
                    push_event(rotenc_pkg::EV_LOG, 4'd1);
                end
            end
        end
    endfunction

    // A pin change never reports an event; a poll reports the oldest queued one, if any.
    function automatic t_report predict_report(input t_enc_item it);
        t_report r;
        r.kind  = rotenc_pkg::EV_NONE;
        r.steps = '0;
        if (it.op == OP_PIN) begin
            step_encoder(it.a, it.b, it.now);
        end else begin
            sample_buttons(it.sw, it.lg, it.now);
            if (ring_rd != ring_wr) begin
                r.kind  = ring_kind[ring_rd];
                r.steps = ring_steps[ring_rd];
                ring_rd = (ring_rd + 1) % EVQ_DEPTH;
            end
        end
        r.held = sw_down;
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Monitor and checker. Both channels are sampled at the rising edge. An accepted item
    // is predicted before an accepted report is popped, so even a report that came out in
    // the same cycle as its item would find its expectation waiting.
    // ------------------------------------------------------------------------------------
    always @(posedge i_clk) begin : report_checker
        t_enc_item it;
        t_report   want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (enc_in.valid && enc_in.ready) begin
                it.op  = enc_in.op;
                it.a   = enc_in.enc_a;
                it.b   = enc_in.enc_b;
                it.sw  = enc_in.sw_level;
                it.lg  = enc_in.log_level;
                it.now = enc_in.now_us;
                expected_reports.push_back(predict_report(it));
                moved = 1'b1;
            end
            if (ev_out.valid && ev_out.ready) begin
                moved = 1'b1;
                report_count++;
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED) begin
                        $display("report %0d: unexpected, kind %0d steps %0d held %0b",
                                 report_count, ev_out.event_kind, ev_out.step_count,
                                 ev_out.button_held);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (ev_out.event_kind !== want.kind || ev_out.step_count !== want.steps
                        || ev_out.button_held !== want.held) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTED) begin
                            $display({"report %0d: expected kind %0d steps %0d held %0b,",
                                      " got kind %0d steps %0d held %0b"},
                                     report_count, want.kind, want.steps, want.held,
                                     ev_out.event_kind, ev_out.step_count,
                                     ev_out.button_held);
                        end
                    end
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    // The run is cut short when nothing has moved on either channel for too long.
    initial begin : watchdog
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("rotary_encoder_event_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Receiver. It holds ready low in random bursts, and for a long stretch when a test asks
    // for one through hold_len.
    // ------------------------------------------------------------------------------------
    initial begin : result_receiver
        int n;
        ev_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                ev_out.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (rcv_idle_pct != 0 && $urandom_range(0, 99) < rcv_idle_pct) begin
                ev_out.ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                ev_out.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------------------

    // Offers one item and returns at the rising edge where it is transferred. Valid stays
    // high into the next item unless an idle burst is drawn.
    task automatic send_item(input t_enc_item it);
        @(negedge i_clk);
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            enc_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        enc_in.op        <= it.op;
        enc_in.enc_a     <= it.a;
        enc_in.enc_b     <= it.b;
        enc_in.sw_level  <= it.sw;
        enc_in.log_level <= it.lg;
        enc_in.now_us    <= it.now;
        enc_in.valid     <= 1'b1;
        do @(posedge i_clk); while (!enc_in.ready);
    endtask

    // The button fields of a pin change are ignored by the block, so they get noise.
    task automatic send_pin(input bit [1:0] ab, input bit [rotenc_pkg::NOW_W-1:0] dt);
        t_enc_item it;
        tb_now += dt;
        stim_ab = ab;
        it.op  = OP_PIN;
        it.a   = ab[1];
        it.b   = ab[0];
        it.sw  = 1'($urandom_range(0, 1));
        it.lg  = 1'($urandom_range(0, 1));
        it.now = tb_now;
        send_item(it);
    endtask

    task automatic send_poll(input bit sw, input bit lg,
                             input bit [rotenc_pkg::NOW_W-1:0] dt);
        t_enc_item it;
        tb_now += dt;
        stim_sw = sw;
        stim_lg = lg;
        it.op  = OP_POLL;
        it.a   = 1'($urandom_range(0, 1));
        it.b   = 1'($urandom_range(0, 1));
        it.sw  = sw;
        it.lg  = lg;
        it.now = tb_now;
        send_item(it);
    endtask

    task automatic send_detent(input bit cw, input bit [rotenc_pkg::NOW_W-1:0] dt0,
                               input bit [rotenc_pkg::NOW_W-1:0] dt1);
        send_pin(cw ? CW_NEXT[stim_ab] : CCW_NEXT[stim_ab], dt0);
        send_pin(cw ? CW_NEXT[stim_ab] : CCW_NEXT[stim_ab], dt1);
    endtask

    // Time steps spread from sub-millisecond (no acceleration, polls too soon) through the
    // acceleration window and press lengths up to full 32-bit jumps that wrap the clock.
    function automatic bit [rotenc_pkg::NOW_W-1:0] pick_dt();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return $urandom_range(0, 999);
        end else if (r < 60) begin
            return $urandom_range(1000, 60000);
        end else if (r < 85) begin
            return $urandom_range(60000, 1500000);
        end else if (r < 97) begin
            return $urandom_range(1500000, 20000000);
        end
        return $urandom;
    endfunction

    // Mostly clean detents in a random direction, polls with buttons that toggle now and
    // then, and a share of raw line noise that breaks half-step pairs apart.
    task automatic run_traffic(input int n_items, input int poll_pct);
        int unsigned r;
        int          sent;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < poll_pct) begin
                send_poll($urandom_range(0, 99) < 35 ? ~stim_sw : stim_sw,
                          $urandom_range(0, 99) < 35 ? ~stim_lg : stim_lg, pick_dt());
                sent += 1;
            end else if (r < poll_pct + (100 - poll_pct) * 8 / 10) begin
                send_detent(1'($urandom_range(0, 1)), pick_dt(), pick_dt());
                sent += 2;
            end else begin
                send_pin(2'($urandom_range(0, 3)), pick_dt());
                sent += 1;
            end
        end
    endtask

    // Stops offering items and waits until every report is back and the block is quiet.
    task automatic drain_reports();
        @(negedge i_clk);
        enc_in.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write: a setup cycle, then an access cycle that ends at the edge where
    // pready is high. The predictor takes the new value at that same edge.
    task automatic reg_write(input logic [rotenc_pkg::CFG_IDX_W-1:0] idx,
                             input bit [rotenc_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            rotenc_pkg::REG_ACCEL_THRESHOLD: thr_ms  = val[rotenc_pkg::ACCEL_THR_W-1:0];
            rotenc_pkg::REG_ACCEL_FACTOR:    fac     = val[rotenc_pkg::ACCEL_FACT_W-1:0];
            rotenc_pkg::REG_LONG_PRESS:      long_ms = val[rotenc_pkg::LONG_PRESS_W-1:0];
            rotenc_pkg::REG_DEBOUNCE:        deb_ms  = val[rotenc_pkg::DEBOUNCE_W-1:0];
            rotenc_pkg::REG_POLL_INTERVAL:   poll_us = val[rotenc_pkg::POLL_INT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Hand-picked items under the reset settings: slow and fast clockwise detents, a slow
    // counterclockwise one, invalid transitions, a reversal, too-early polls, short, long
    // and bounced presses of both buttons, and the time field at its extremes with a wrap.
    task automatic test_directed();
        snd_idle_pct = 10;
        rcv_idle_pct = 10;
        send_poll(1'b1, 1'b1, 0);            // at time zero, too soon to sample
        send_pin(2'b01, 500);
        send_pin(2'b00, 100);                // clockwise, gap below 1 ms
        send_pin(2'b10, 20000);
        send_pin(2'b11, 100);                // clockwise, fast
        send_pin(2'b00, 3000);               // both lines at once
        send_pin(2'b00, 3000);               // no change
        send_pin(2'b01, 1000000);
        send_pin(2'b11, 1000);               // counterclockwise, slow
        send_pin(2'b01, 500);
        send_pin(2'b11, 500);                // one step forward and back again
        send_poll(1'b1, 1'b1, 2000);
        send_poll(1'b0, 1'b0, 500);          // press missed, interval not yet over
        send_poll(1'b0, 1'b0, 1000);         // both buttons down
        send_poll(1'b1, 1'b1, 30000);        // both released inside the debounce time
        send_poll(1'b0, 1'b1, 2000);
        send_poll(1'b1, 1'b0, 100000);       // short press, logger down
        send_poll(1'b0, 1'b1, 60000);        // logger press, encoder button down
        send_poll(1'b1, 1'b1, 900000);       // long press
        tb_now = '1;
        send_pin(2'b01, 0);                  // all ones on the time field
        send_pin(2'b00, 8000);               // time wraps past zero
        send_pin(2'b10, 5000);
        send_pin(2'b11, 1000);
        send_poll(1'b1, 1'b1, 0);
        send_poll(1'b1, 1'b1, 1000);
    endtask

    // Fills the ring past its capacity with detents and with button releases that land
    // on a full or nearly full ring, so that one of a pair of events is dropped.
    task automatic test_ring_overflow();
        snd_idle_pct = 10;
        rcv_idle_pct = 10;
        repeat (EVQ_DEPTH + 1) send_poll(1'b1, 1'b1, 100000);
        send_poll(1'b0, 1'b0, 100000);
        repeat (EVQ_DEPTH) send_detent(1'b1, 2000, 2000);
        send_poll(1'b1, 1'b1, 2000);         // both releases find the ring full
        send_poll(1'b0, 1'b0, 2000);
        send_detent(1'b0, 2000, 2000);
        send_poll(1'b1, 1'b1, 100000);       // only the encoder release still fits
        repeat (EVQ_DEPTH + 1) send_poll(1'b1, 1'b1, 100000);
    endtask

    // Random traffic under several settings: all extremes, the zero factor and the zero
    // interval, and two random settings. Each phase starts from an idle block.
    task automatic test_config_sweep();
        t_setting plan [6];
        int       p;
        plan[0] = '{10'd1000, 4'd15, 14'd10000, 10'd1000, 16'd65535};
        plan[1] = '{10'd0, 4'd0, 14'd0, 10'd0, 16'd0};
        plan[2] = '{10'd1, 4'd1, 14'd1, 10'd1, 16'd1};
        plan[3] = '{10'd40, 4'd0, 14'd800, 10'd50, 16'd0};
        for (p = 4; p < 6; p++) begin
            plan[p].thr  = 10'($urandom_range(0, 1000));
            plan[p].fac  = 4'($urandom_range(0, 15));
            plan[p].lng  = 14'($urandom_range(0, 10000));
            plan[p].deb  = 10'($urandom_range(0, 1000));
            plan[p].poll = 16'($urandom_range(0, 65535));
        end
        for (p = 0; p < 6; p++) begin
            drain_reports();
            reg_write(rotenc_pkg::REG_ACCEL_THRESHOLD, 32'(plan[p].thr));
            reg_write(rotenc_pkg::REG_ACCEL_FACTOR, 32'(plan[p].fac));
            reg_write(rotenc_pkg::REG_LONG_PRESS, 32'(plan[p].lng));
            reg_write(rotenc_pkg::REG_DEBOUNCE, 32'(plan[p].deb));
            reg_write(rotenc_pkg::REG_POLL_INTERVAL, 32'(plan[p].poll));
            // Phases alternate between no idling, even idling and a slow receiver.
            case (p % 3)
                0: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
                1: begin
                    snd_idle_pct = 20;
                    rcv_idle_pct = 20;
                end
                default: begin
                    snd_idle_pct = 5;
                    rcv_idle_pct = 40;
                end
            endcase
            run_traffic(250, $urandom_range(30, 60));
        end
    endtask

    // The receiver stops for a long stretch while the sender keeps offering items, so the
    // block fills up and has to hold off its input until reports drain again.
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 20;
        hold_len = 400;
        run_traffic(100, 50);
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_streaming();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_traffic(300, 45);
    endtask

    initial begin : main
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        enc_in.valid     = 1'b0;
        enc_in.op        = OP_PIN;
        enc_in.enc_a     = 1'b1;
        enc_in.enc_b     = 1'b1;
        enc_in.sw_level  = 1'b1;
        enc_in.log_level = 1'b1;
        enc_in.now_us    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_ring_overflow();
        test_config_sweep();
        test_backpressure();
        test_streaming();

        drain_reports();
        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("rotary_encoder_event_unit: match");
        end else begin
            $display("rotary_encoder_event_unit: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/rotenc_pkg.sv
hdl/rotenc_in_if.sv
hdl/rotenc_out_if.sv
hdl/rotary_encoder_event_unit.sv
dv/tb_top.sv
